// File: sv/vector3_rotation_unit_macros.svh
// Assertion macros for the rotation pipeline.
`ifndef VECTOR3_ROTATION_UNIT_MACROS_SVH
`define VECTOR3_ROTATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define V3R_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("vector3_rotation_unit: check failed");
`define V3R_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("vector3_rotation_unit: check failed");
`else
`define V3R_ASSERT_IMP(name, pre, post)
`define V3R_ASSERT_NXT(name, pre, post)
`endif
`endif

// File: sv/v3r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package v3r_pkg;
	localparam int VECTOR_WIDTH = 32;
	localparam int ANGLE_WIDTH = 16;
	localparam int TRIG_WIDTH = 20;
	localparam int TRIG_STAGES = 24;
	localparam int PIPE_STAGES = TRIG_STAGES + 4;

	localparam logic [1:0] OP_ROT_YX = 2'd0;
	localparam logic [1:0] OP_ROT_XY = 2'd1;
	localparam logic [1:0] OP_ROT_Z = 2'd2;

	typedef logic signed [VECTOR_WIDTH-1:0] vec_t;
	typedef logic [ANGLE_WIDTH-1:0] angle_t;
	typedef logic signed [TRIG_WIDTH-1:0] trig_t;

	localparam vec_t VEC_MAX = {1'b0, {(VECTOR_WIDTH-1){1'b1}}};
	localparam vec_t VEC_MIN = {1'b1, {(VECTOR_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [1:0] opcode;
		vec_t vec_x;
		vec_t vec_y;
		vec_t vec_z;
		angle_t angle_first;
		angle_t angle_second;
	} v3r_cmd_t;

	typedef struct packed {
		vec_t rot_x;
		vec_t rot_y;
		vec_t rot_z;
		logic saturated;
	} v3r_res_t;
endpackage
`default_nettype wire

// File: sv/v3r_trig.sv
`timescale 1ns / 1ps
`default_nettype none
module v3r_trig import v3r_pkg::*; (
	input logic clk,
	input logic [TRIG_STAGES-1:0] en,
	input angle_t angle,
	output trig_t sin_q,
	output trig_t cos_q
);
	localparam int QB = ANGLE_WIDTH - 2;
	localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

	function automatic trig_t to_q18(input logic signed [33:0] v);
		logic signed [33:0] w;
		begin
			w = (v + 34'sd2048) >>> 12;
			if (w < 34'sd0) begin
				to_q18 = '0;
			end else if (w > 34'sd262144) begin
				to_q18 = 20'sd262144;
			end else begin
				to_q18 = TRIG_WIDTH'(w);
			end
		end
	endfunction

	logic [QB+30:0] t_prod;
	logic [1:0] quad_s1, quad_s2;
	logic [30:0] t_s1, t_s2;
	logic [61:0] t_sq;
	logic [31:0] t2_s2;

	assign t_prod = (QB+31)'(angle[QB-1:0]) * (QB+31)'(PI_HALF_Q30);
	assign t_sq = 62'(t_s1) * 62'(t_s1);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			quad_s1 <= angle[ANGLE_WIDTH-1 -: 2];
			t_s1 <= t_prod[QB+30:QB];
		end
		if (en[1]) begin
			quad_s2 <= quad_s1;
			t_s2 <= t_s1;
			t2_s2 <= t_sq[61:30];
		end
	end

	logic [31:0] ts_c [1:7];
	logic [31:0] tc_c [1:7];
	logic [31:0] t2_c [1:7];
	logic signed [33:0] ss_c [1:7];
	logic signed [33:0] cs_c [1:7];
	logic [1:0] qd_c [1:7];

	for (genvar k = 1; k <= 7; k++) begin : g_term
		localparam int DS = (2*k) * (2*k+1);
		localparam int DC = (2*k-1) * (2*k);
		localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
		localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
		localparam int SA = 2 + 3*(k-1);

		logic [31:0] ts_i, tc_i, t2_i;
		logic signed [33:0] ss_i, cs_i;
		logic [1:0] qd_i;

		if (k == 1) begin : g_first
			assign ts_i = 32'(t_s2);
			assign tc_i = 32'h4000_0000;
			assign t2_i = t2_s2;
			assign ss_i = $signed(34'(t_s2));
			assign cs_i = 34'sh4000_0000;
			assign qd_i = quad_s2;
		end else begin : g_next
			assign ts_i = ts_c[k-1];
			assign tc_i = tc_c[k-1];
			assign t2_i = t2_c[k-1];
			assign ss_i = ss_c[k-1];
			assign cs_i = cs_c[k-1];
			assign qd_i = qd_c[k-1];
		end

		logic [63:0] ps_sa, pc_sa;
		logic [31:0] t2_sa, t2_sb;
		logic signed [33:0] ss_sa, cs_sa, ss_sb, cs_sb;
		logic [1:0] qd_sa, qd_sb;
		logic [31:0] xs_sb, xc_sb;
		logic [63:0] ms_sb, mc_sb;
		logic [31:0] q0s, q0c, qs, qc;
		logic [33:0] rs, rc;

		always_ff @(posedge clk) begin
			if (en[SA]) begin
				ps_sa <= 64'(ts_i) * 64'(t2_i);
				pc_sa <= 64'(tc_i) * 64'(t2_i);
				t2_sa <= t2_i;
				ss_sa <= ss_i;
				cs_sa <= cs_i;
				qd_sa <= qd_i;
			end
			if (en[SA+1]) begin
				xs_sb <= ps_sa[61:30];
				xc_sb <= pc_sa[61:30];
				ms_sb <= 64'(ps_sa[61:30]) * 64'(MS);
				mc_sb <= 64'(pc_sa[61:30]) * 64'(MC);
				t2_sb <= t2_sa;
				ss_sb <= ss_sa;
				cs_sb <= cs_sa;
				qd_sb <= qd_sa;
			end
		end

		always_comb begin
			q0s = ms_sb[63:32];
			q0c = mc_sb[63:32];
			rs = 34'(xs_sb) - 34'(q0s) * 34'(DS);
			rc = 34'(xc_sb) - 34'(q0c) * 34'(DC);
			qs = (rs >= 34'(DS)) ? q0s + 32'd1 : q0s;
			qc = (rc >= 34'(DC)) ? q0c + 32'd1 : q0c;
		end

		always_ff @(posedge clk) begin
			if (en[SA+2]) begin
				ts_c[k] <= qs;
				tc_c[k] <= qc;
				t2_c[k] <= t2_sb;
				qd_c[k] <= qd_sb;
				if (k % 2 == 1) begin
					ss_c[k] <= ss_sb - $signed(34'(qs));
					cs_c[k] <= cs_sb - $signed(34'(qc));
				end else begin
					ss_c[k] <= ss_sb + $signed(34'(qs));
					cs_c[k] <= cs_sb + $signed(34'(qc));
				end
			end
		end
	end

	trig_t s_v, c_v, sin_sf, cos_sf;

	assign s_v = to_q18(ss_c[7]);
	assign c_v = to_q18(cs_c[7]);

	always_ff @(posedge clk) begin
		if (en[TRIG_STAGES-1]) begin
			case (qd_c[7])
				2'd0: begin
					sin_sf <= s_v;
					cos_sf <= c_v;
				end
				2'd1: begin
					sin_sf <= c_v;
					cos_sf <= -s_v;
				end
				2'd2: begin
					sin_sf <= -s_v;
					cos_sf <= -c_v;
				end
				default: begin
					sin_sf <= -c_v;
					cos_sf <= s_v;
				end
			endcase
		end
	end

	assign sin_q = sin_sf;
	assign cos_q = cos_sf;
endmodule
`default_nettype wire

// File: sv/vector3_rotation_unit.sv
// Throughput: one item per cycle, unless res_ready is low while every stage is
// full; sine and cosine come from a 24-stage Taylor pipeline, followed by
// trig-product, matrix, multiply and sum stages.
// A stalled output holds every valid stage up to the first empty one; empty stages keep taking items.
// Reset clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_rotation_unit_macros.svh"
module vector3_rotation_unit import v3r_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_ready,
	input v3r_cmd_t cmd,
	output logic res_valid,
	input logic res_ready,
	output v3r_res_t res
);
	localparam int TS = TRIG_STAGES;
	localparam int N = PIPE_STAGES;
	localparam int PW = 2 * TRIG_WIDTH;
	localparam int MW = VECTOR_WIDTH + TRIG_WIDTH;
	localparam int SW = MW + 2;
	localparam int RW = SW - 18;

	logic [N-1:0] vld_s, en;
	v3r_cmd_t cmd_s [0:TS+1];

	always_comb begin
		en[N-1] = !vld_s[N-1] || res_ready;
		for (int i = N - 2; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (vld_s & ~en) | ({vld_s[N-2:0], cmd_valid} & en);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cmd_s[0] <= cmd;
		end
		for (int i = 1; i <= TS + 1; i++) begin
			if (en[i]) begin
				cmd_s[i] <= cmd_s[i-1];
			end
		end
	end

	trig_t sa, ca, sb, cb;

	v3r_trig u_trig_a (
		.clk(clk),
		.en(en[TS-1:0]),
		.angle(cmd.angle_first),
		.sin_q(sa),
		.cos_q(ca)
	);

	v3r_trig u_trig_b (
		.clk(clk),
		.en(en[TS-1:0]),
		.angle(cmd.angle_second),
		.sin_q(sb),
		.cos_q(cb)
	);

	function automatic trig_t rnd18(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] w;
		begin
			w = (p + PW'(131072)) >>> 18;
			rnd18 = TRIG_WIDTH'(w);
		end
	endfunction

	trig_t a_s, b_s, c_s, d_s;
	logic signed [PW-1:0] ac_s, ad_s, bc_s, bd_s;

	always_ff @(posedge clk) begin
		if (en[TS]) begin
			a_s <= sa;
			b_s <= ca;
			c_s <= sb;
			d_s <= cb;
			ac_s <= sa * sb;
			ad_s <= sa * cb;
			bc_s <= ca * sb;
			bd_s <= ca * cb;
		end
	end

	trig_t mat_c [0:2][0:2];
	trig_t m_s [0:2][0:2];
	trig_t one_c, zero_c;

	assign one_c = 20'sd262144;
	assign zero_c = '0;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mat_c[r][c] = (r == c) ? one_c : zero_c;
			end
		end
		case (cmd_s[TS].opcode)
			OP_ROT_YX: begin
				mat_c[0][0] = d_s;
				mat_c[0][2] = c_s;
				mat_c[1][0] = rnd18(ac_s);
				mat_c[1][1] = b_s;
				mat_c[1][2] = -rnd18(ad_s);
				mat_c[2][0] = -rnd18(bc_s);
				mat_c[2][1] = a_s;
				mat_c[2][2] = rnd18(bd_s);
			end
			OP_ROT_XY: begin
				mat_c[0][0] = b_s;
				mat_c[0][1] = rnd18(ac_s);
				mat_c[0][2] = rnd18(ad_s);
				mat_c[1][1] = d_s;
				mat_c[1][2] = -c_s;
				mat_c[2][0] = -a_s;
				mat_c[2][1] = rnd18(bc_s);
				mat_c[2][2] = rnd18(bd_s);
			end
			OP_ROT_Z: begin
				mat_c[0][0] = b_s;
				mat_c[0][1] = -a_s;
				mat_c[1][0] = a_s;
				mat_c[1][1] = b_s;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[TS+1]) begin
			m_s <= mat_c;
		end
	end

	vec_t v_c [0:2];
	logic signed [MW-1:0] prod_s [0:2][0:2];

	assign v_c[0] = cmd_s[TS+1].vec_x;
	assign v_c[1] = cmd_s[TS+1].vec_y;
	assign v_c[2] = cmd_s[TS+1].vec_z;

	always_ff @(posedge clk) begin
		if (en[TS+2]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s[r][c] <= MW'(v_c[c]) * MW'(m_s[r][c]);
				end
			end
		end
	end

	logic signed [SW-1:0] sum_c [0:2];
	logic signed [RW-1:0] rr_c [0:2];
	logic signed [RW-1:0] lim_hi, lim_lo;
	vec_t out_c [0:2];
	logic [2:0] clip_c;
	v3r_res_t res_s;

	assign lim_hi = RW'(VEC_MAX);
	assign lim_lo = RW'(VEC_MIN);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = SW'(prod_s[r][0]) + SW'(prod_s[r][1]) + SW'(prod_s[r][2])
				+ SW'(131072);
			rr_c[r] = RW'(sum_c[r] >>> 18);
			clip_c[r] = 1'b0;
			out_c[r] = VECTOR_WIDTH'(rr_c[r]);
			if (rr_c[r] > lim_hi) begin
				out_c[r] = VEC_MAX;
				clip_c[r] = 1'b1;
			end else if (rr_c[r] < lim_lo) begin
				out_c[r] = VEC_MIN;
				clip_c[r] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			res_s.rot_x <= out_c[0];
			res_s.rot_y <= out_c[1];
			res_s.rot_z <= out_c[2];
			res_s.saturated <= |clip_c;
		end
	end

	assign res = res_s;
	assign res_valid = vld_s[N-1];
	assign cmd_ready = en[0];

	`V3R_ASSERT_IMP(a_empty_out_ready, !res_valid, cmd_ready)
	`V3R_ASSERT_NXT(a_advance_out, vld_s[N-2] && en[N-1], res_valid)
	`V3R_ASSERT_IMP(a_sat_at_limit, res_valid && res.saturated, res.rot_x == VEC_MAX || res.rot_x == VEC_MIN || res.rot_y == VEC_MAX || res.rot_y == VEC_MIN || res.rot_z == VEC_MAX || res.rot_z == VEC_MIN)
endmodule
`default_nettype wire
